[hw/rtl/hdr_pixel_exposure_gamma_map_top_defines.svh]
// Assertion macros for the checker file of the HDR exposure/gamma mapper.
`ifndef HDR_PIXEL_EXPOSURE_GAMMA_MAP_TOP_DEFINES_SVH
`define HDR_PIXEL_EXPOSURE_GAMMA_MAP_TOP_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define HPEGM_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent at an edge implies the consequent at the same edge.
`define HPEGM_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hpegm_pkg.sv]
// Shared types, constants and constant functions of the HDR exposure/gamma mapper.
package hpegm_pkg;

    localparam int FRAC_BITS  = 20;
    localparam int LOG_STEPS  = 20;
    localparam int EXP_STEPS  = 20;
    localparam int DIV_BITS   = 45;
    // decode, normalize, log2, log sum, divide, split, pow2, shift, two multiplies, merge
    localparam int PIPE_DEPTH = 2 + LOG_STEPS + 1 + DIV_BITS + 1 + EXP_STEPS + 3 + 1;

    localparam logic [29:0] LOG_OFFSET  = 30'd2594104;
    localparam logic [18:0] SCALE_0332  = 19'd348127;
    localparam logic [11:0] MAX_SHALLOW = 12'd255;
    localparam logic [11:0] MAX_DEEP    = 12'd4095;

    localparam logic [2:0] REG_EXP_R   = 3'd0;
    localparam logic [2:0] REG_EXP_G   = 3'd1;
    localparam logic [2:0] REG_EXP_B   = 3'd2;
    localparam logic [2:0] REG_GAMMA_R = 3'd3;
    localparam logic [2:0] REG_GAMMA_G = 3'd4;
    localparam logic [2:0] REG_GAMMA_B = 3'd5;
    localparam logic [2:0] REG_FORMATS = 3'd6;
    localparam logic [2:0] REG_DEEP    = 3'd7;

    typedef enum logic [1:0] {FMT_HALF, FMT_FLOAT, FMT_UINT, FMT_NONE} t_fmt;

    // Result override, decided at decode or at the range check, and carried down the lane.
    typedef enum logic [1:0] {FIX_NONE, FIX_ZERO, FIX_MAX, FIX_RAW} t_fix;

    typedef struct packed {
        t_fix        kind;
        logic [11:0] raw;
    } t_side;

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        int          i;
        rem = n;
        res = '0;
        b   = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) with 30 fraction bits, by repeated floor square roots from 2.0
    function automatic logic [30:0] root_const(input int k);
        logic [63:0] r;
        int          j;
        r = 64'd1 << 31;
        for (j = 1; j <= k; j++) begin
            r = isqrt64(r << 30);
        end
        return r[30:0];
    endfunction

endpackage

[hw/rtl/hpegm_log2.sv]
// Pipelined square-and-compare log2 of a significand, one fraction bit per stage.
module hpegm_log2 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [30:0]        i_x,
    input  logic signed [8:0]  i_e2,
    input  hpegm_pkg::t_side   i_side,
    output logic               o_valid,
    output logic [19:0]        o_frac,
    output logic signed [8:0]  o_e2,
    output hpegm_pkg::t_side   o_side
);
    import hpegm_pkg::*;

    logic [LOG_STEPS-1:0] r_valid;
    logic [30:0]          s_x    [0:LOG_STEPS-1];
    logic [19:0]          s_f    [0:LOG_STEPS-1];
    logic signed [8:0]    s_e2   [0:LOG_STEPS-1];
    t_side                s_side [0:LOG_STEPS-1];
    logic [30:0]          n_x    [0:LOG_STEPS-1];
    logic [19:0]          n_f    [0:LOG_STEPS-1];
    logic [30:0]          r_x    [0:LOG_STEPS-1];
    logic [19:0]          r_f    [0:LOG_STEPS-1];
    logic signed [8:0]    r_e2   [0:LOG_STEPS-1];
    t_side                r_side [0:LOG_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[LOG_STEPS-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < LOG_STEPS; k++) begin : g_step
        logic [61:0] sq;
        logic [31:0] y;

        if (k == 0) begin : g_first
            assign s_x[k]    = i_x;
            assign s_f[k]    = '0;
            assign s_e2[k]   = i_e2;
            assign s_side[k] = i_side;
        end else begin : g_next
            assign s_x[k]    = r_x[k-1];
            assign s_f[k]    = r_f[k-1];
            assign s_e2[k]   = r_e2[k-1];
            assign s_side[k] = r_side[k-1];
        end

        // square, then fold back into [1,2) and emit one bit
        assign sq     = {31'b0, s_x[k]} * {31'b0, s_x[k]};
        assign y      = sq[61:30];
        assign n_x[k] = y[31] ? y[31:1] : y[30:0];
        assign n_f[k] = {s_f[k][18:0], y[31]};

        always_ff @(posedge i_clk) begin
            r_x[k]    <= n_x[k];
            r_f[k]    <= n_f[k];
            r_e2[k]   <= s_e2[k];
            r_side[k] <= s_side[k];
        end
    end

    assign o_valid = r_valid[LOG_STEPS-1];
    assign o_frac  = r_f[LOG_STEPS-1];
    assign o_e2    = r_e2[LOG_STEPS-1];
    assign o_side  = r_side[LOG_STEPS-1];

endmodule

[hw/rtl/hpegm_div.sv]
// Pipelined restoring divider of the log magnitude by gamma, one quotient bit per stage.
module hpegm_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [44:0]          i_num,
    input  logic                 i_neg,
    input  hpegm_pkg::t_side     i_side,
    input  logic [20:0]          i_gamma,
    output logic                 o_valid,
    output logic [44:0]          o_quot,
    output logic                 o_neg,
    output hpegm_pkg::t_side     o_side
);
    import hpegm_pkg::*;

    logic [20:0]         g_eff;
    logic [DIV_BITS-1:0] r_valid;
    logic [20:0]         s_rem  [0:DIV_BITS-1];
    logic [44:0]         s_w    [0:DIV_BITS-1];
    logic                s_neg  [0:DIV_BITS-1];
    t_side               s_side [0:DIV_BITS-1];
    logic [20:0]         n_rem  [0:DIV_BITS-1];
    logic [44:0]         n_w    [0:DIV_BITS-1];
    logic [20:0]         r_rem  [0:DIV_BITS-1];
    logic [44:0]         r_w    [0:DIV_BITS-1];
    logic                r_neg  [0:DIV_BITS-1];
    t_side               r_side [0:DIV_BITS-1];

    // a zero gamma divides by the smallest step
    assign g_eff = (i_gamma == '0) ? 21'd1 : i_gamma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[DIV_BITS-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
        logic [21:0] trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign s_rem[k]  = '0;
            assign s_w[k]    = i_num;
            assign s_neg[k]  = i_neg;
            assign s_side[k] = i_side;
        end else begin : g_next
            assign s_rem[k]  = r_rem[k-1];
            assign s_w[k]    = r_w[k-1];
            assign s_neg[k]  = r_neg[k-1];
            assign s_side[k] = r_side[k-1];
        end

        // dividend bits leave at the top while quotient bits enter at the bottom
        assign trial    = {s_rem[k], s_w[k][44]};
        assign ge       = trial >= {1'b0, g_eff};
        assign n_rem[k] = ge ? 21'(trial - {1'b0, g_eff}) : trial[20:0];
        assign n_w[k]   = {s_w[k][43:0], ge};

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem[k];
            r_w[k]    <= n_w[k];
            r_neg[k]  <= s_neg[k];
            r_side[k] <= s_side[k];
        end
    end

    assign o_valid = r_valid[DIV_BITS-1];
    assign o_quot  = r_w[DIV_BITS-1];
    assign o_neg   = r_neg[DIV_BITS-1];
    assign o_side  = r_side[DIV_BITS-1];

endmodule

[hw/rtl/hpegm_pow2.sv]
// Pipelined 2^frac product over the root constants, one fraction bit per stage.
module hpegm_pow2 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [19:0]        i_frac,
    input  logic signed [6:0]  i_int,
    input  hpegm_pkg::t_side   i_side,
    output logic               o_valid,
    output logic [30:0]        o_p,
    output logic signed [6:0]  o_int,
    output hpegm_pkg::t_side   o_side
);
    import hpegm_pkg::*;

    logic [EXP_STEPS-1:0] r_valid;
    logic [30:0]          s_p    [0:EXP_STEPS-1];
    logic [19:0]          s_f    [0:EXP_STEPS-1];
    logic signed [6:0]    s_i    [0:EXP_STEPS-1];
    t_side                s_side [0:EXP_STEPS-1];
    logic [30:0]          n_p    [0:EXP_STEPS-1];
    logic [30:0]          r_p    [0:EXP_STEPS-1];
    logic [19:0]          r_f    [0:EXP_STEPS-1];
    logic signed [6:0]    r_i    [0:EXP_STEPS-1];
    t_side                r_side [0:EXP_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[EXP_STEPS-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < EXP_STEPS; k++) begin : g_step
        localparam logic [30:0] ROOT_K = root_const(k + 1);
        logic [61:0] prod;

        if (k == 0) begin : g_first
            assign s_p[k]    = 31'h4000_0000;
            assign s_f[k]    = i_frac;
            assign s_i[k]    = i_int;
            assign s_side[k] = i_side;
        end else begin : g_next
            assign s_p[k]    = r_p[k-1];
            assign s_f[k]    = r_f[k-1];
            assign s_i[k]    = r_i[k-1];
            assign s_side[k] = r_side[k-1];
        end

        // the product stays below 2.0, so 31 bits hold it
        assign prod   = {31'b0, s_p[k]} * {31'b0, ROOT_K};
        assign n_p[k] = s_f[k][EXP_STEPS-1-k] ? prod[60:30] : s_p[k];

        always_ff @(posedge i_clk) begin
            r_p[k]    <= n_p[k];
            r_f[k]    <= s_f[k];
            r_i[k]    <= s_i[k];
            r_side[k] <= s_side[k];
        end
    end

    assign o_valid = r_valid[EXP_STEPS-1];
    assign o_p     = r_p[EXP_STEPS-1];
    assign o_int   = r_i[EXP_STEPS-1];
    assign o_side  = r_side[EXP_STEPS-1];

endmodule

[hw/rtl/hpegm_lane.sv]
// One channel lane: sample decode, log2, gamma divide, pow2 and display scaling.
module hpegm_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [31:0]        i_sample,
    input  hpegm_pkg::t_fmt    i_fmt,
    input  logic               i_deep,
    input  logic signed [14:0] i_exposure,
    input  logic [20:0]        i_gamma,
    output logic               o_valid,
    output logic [11:0]        o_level
);
    import hpegm_pkg::*;

    localparam logic [44:0] T_MAX_LIMIT  = 45'd2097152;
    localparam logic [44:0] T_ZERO_LIMIT = 45'd41943040;

    logic [11:0] maxv;
    assign maxv = i_deep ? MAX_DEEP : MAX_SHALLOW;

    // ---------------- decode
    logic [23:0]       n_d_m;
    logic signed [8:0] n_d_e2;
    t_side             n_d_side;
    logic              r_d_valid;
    logic [23:0]       r_d_m;
    logic signed [8:0] r_d_e2;
    t_side             r_d_side;

    always_comb begin
        n_d_m         = '0;
        n_d_e2        = '0;
        n_d_side.kind = FIX_NONE;
        n_d_side.raw  = '0;
        case (i_fmt)
            FMT_HALF: begin
                if (i_sample[14:10] == 5'h1f) begin
                    n_d_side.kind = (i_sample[9:0] == '0 && !i_sample[15]) ? FIX_MAX : FIX_ZERO;
                end else if (i_sample[15] || i_sample[14:0] == '0) begin
                    n_d_side.kind = FIX_ZERO;
                end else if (i_sample[14:10] == '0) begin
                    n_d_m  = {1'b0, i_sample[9:0], 13'b0};
                    n_d_e2 = -9'sd14;
                end else begin
                    n_d_m  = {1'b1, i_sample[9:0], 13'b0};
                    n_d_e2 = $signed({4'b0, i_sample[14:10]}) - 9'sd15;
                end
            end
            FMT_FLOAT: begin
                if (i_sample[30:23] == 8'hff) begin
                    n_d_side.kind = (i_sample[22:0] == '0 && !i_sample[31]) ? FIX_MAX : FIX_ZERO;
                end else if (i_sample[31] || i_sample[30:0] == '0) begin
                    n_d_side.kind = FIX_ZERO;
                end else if (i_sample[30:23] == '0) begin
                    n_d_m  = {1'b0, i_sample[22:0]};
                    n_d_e2 = -9'sd126;
                end else begin
                    n_d_m  = {1'b1, i_sample[22:0]};
                    n_d_e2 = $signed({1'b0, i_sample[30:23]}) - 9'sd127;
                end
            end
            FMT_UINT: begin
                n_d_side.kind = FIX_RAW;
                n_d_side.raw  = (|i_sample[31:12] || i_sample[11:0] > maxv) ? maxv
                                                                             : i_sample[11:0];
            end
            default: begin
                n_d_side.kind = FIX_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_m    <= n_d_m;
        r_d_e2   <= n_d_e2;
        r_d_side <= n_d_side;
    end

    // ---------------- normalize denormals
    logic [4:0]        lz;
    logic              r_n_valid;
    logic [23:0]       r_n_m;
    logic signed [8:0] r_n_e2;
    t_side             r_n_side;

    always_comb begin
        lz = '0;
        for (int i = 0; i < 24; i++) begin
            if (r_d_m[i]) begin
                lz = 5'(23 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else begin
            r_n_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n_m    <= r_d_m << lz;
        r_n_e2   <= r_d_e2 - $signed({4'b0, lz});
        r_n_side <= r_d_side;
    end

    // ---------------- log2
    logic              l_valid;
    logic [19:0]       l_frac;
    logic signed [8:0] l_e2;
    t_side             l_side;

    hpegm_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_n_valid),
        .i_x     ({r_n_m, 7'b0}),
        .i_e2    (r_n_e2),
        .i_side  (r_n_side),
        .o_valid (l_valid),
        .o_frac  (l_frac),
        .o_e2    (l_e2),
        .o_side  (l_side)
    );

    // ---------------- exposed log value, split into sign and magnitude
    logic [29:0] l_sum;
    logic        r_l_valid;
    logic        r_l_neg;
    logic [28:0] r_l_mag;
    t_side       r_l_side;

    assign l_sum = {l_e2[8], l_e2, 20'b0} + {10'b0, l_frac}
                 + {{3{i_exposure[14]}}, i_exposure, 12'b0} + LOG_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid <= 1'b0;
        end else begin
            r_l_valid <= l_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l_neg  <= l_sum[29];
        r_l_mag  <= 29'(l_sum[29] ? (~l_sum + 30'd1) : l_sum);
        r_l_side <= l_side;
    end

    // ---------------- divide by gamma
    logic        q_valid;
    logic [44:0] q_quot;
    logic        q_neg;
    t_side       q_side;

    hpegm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_l_valid),
        .i_num   ({r_l_mag, 16'b0}),
        .i_neg   (r_l_neg),
        .i_side  (r_l_side),
        .i_gamma (i_gamma),
        .o_valid (q_valid),
        .o_quot  (q_quot),
        .o_neg   (q_neg),
        .o_side  (q_side)
    );

    // ---------------- split into integer and fraction, catch the range limits
    logic [26:0]       t_low;
    t_side             n_t_side;
    logic              r_t_valid;
    logic [19:0]       r_t_frac;
    logic signed [6:0] r_t_int;
    t_side             r_t_side;

    assign t_low = q_neg ? 27'(~q_quot + 45'd1) : q_quot[26:0];

    always_comb begin
        n_t_side = q_side;
        if (q_side.kind == FIX_NONE) begin
            if (!q_neg && q_quot >= T_MAX_LIMIT) begin
                n_t_side.kind = FIX_MAX;
            end else if (q_neg && q_quot > T_ZERO_LIMIT) begin
                n_t_side.kind = FIX_ZERO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else begin
            r_t_valid <= q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_frac <= t_low[19:0];
        r_t_int  <= $signed(t_low[26:20]);
        r_t_side <= n_t_side;
    end

    // ---------------- 2^frac
    logic              p_valid;
    logic [30:0]       p_p;
    logic signed [6:0] p_int;
    t_side             p_side;

    hpegm_pow2 u_pow2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_t_valid),
        .i_frac  (r_t_frac),
        .i_int   (r_t_int),
        .i_side  (r_t_side),
        .o_valid (p_valid),
        .o_p     (p_p),
        .o_int   (p_int),
        .o_side  (p_side)
    );

    // ---------------- integer shift: amount is 1 - int, from 0 to 41
    logic [6:0]  sh;
    logic        r_s_valid;
    logic [31:0] r_s_ps;
    t_side       r_s_side;

    assign sh = 7'd1 - p_int;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else begin
            r_s_valid <= p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_ps   <= {p_p, 1'b0} >> sh;
        r_s_side <= p_side;
    end

    // ---------------- scale by 0.332
    logic        r_m_valid;
    logic [50:0] r_m_q;
    t_side       r_m_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_q    <= {19'b0, r_s_ps} * {32'b0, SCALE_0332};
        r_m_side <= r_s_side;
    end

    // ---------------- scale by the output maximum, clamp, apply overrides
    logic [62:0] q2;
    logic [12:0] lvl;
    logic [11:0] n_level;
    logic        r_o_valid;
    logic [11:0] r_o_level;

    // max is 2^n - 1: shift and subtract
    assign q2  = i_deep ? ({r_m_q, 12'b0} - {12'b0, r_m_q})
                        : ({4'b0, r_m_q, 8'b0} - {12'b0, r_m_q});
    assign lvl = q2[62:50];

    always_comb begin
        case (r_m_side.kind)
            FIX_ZERO: n_level = '0;
            FIX_MAX:  n_level = maxv;
            FIX_RAW:  n_level = r_m_side.raw;
            default:  n_level = (lvl > {1'b0, maxv}) ? maxv : lvl[11:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_level <= n_level;
    end

    assign o_valid = r_o_valid;
    assign o_level = r_o_level;

endmodule

[hw/rtl/hdr_pixel_exposure_gamma_map_top.sv]
// Top level of the HDR exposure/gamma mapper: configuration registers, three lanes, merge.
//
// Usage:
//   Request: drive the three sample ports and raise start. A request is taken
//   at every rising edge where start is high and busy is low; busy stays low,
//   so one pixel may be taken in every cycle.
//   Result: o_strobe is high for one cycle with the three levels. The
//   depth of the path from request to result is set by the per-lane
//   pipeline and the merge register: 20 log2 square stages, 45 divider
//   stages (one quotient bit each), 20 pow2 multiply stages, plus decode,
//   normalize, log sum, split, shift and scaling stages.
//   Results leave in request order, one per cycle at full rate.
//   The receiver cannot stall; every strobed result must be taken.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at
//   the clock edge. Write only while no request is in flight.
//   Reset (synchronous, active low) clears the pipeline and loads the
//   register defaults: exposure 0, gamma 2.2, half samples, 8-bit levels.
module hdr_pixel_exposure_gamma_map_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_red_sample,
    input  logic [31:0] i_green_sample,
    input  logic [31:0] i_blue_sample,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [20:0] i_cfg_data,
    output logic        o_strobe,
    output logic [11:0] o_red_level,
    output logic [11:0] o_green_level,
    output logic [11:0] o_blue_level
);
    import hpegm_pkg::*;

    logic signed [14:0] r_exp_r, r_exp_g, r_exp_b;
    logic [20:0]        r_gamma_r, r_gamma_g, r_gamma_b;
    logic [5:0]         r_formats;
    logic               r_deep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_r   <= '0;
            r_exp_g   <= '0;
            r_exp_b   <= '0;
            r_gamma_r <= 21'd144179;
            r_gamma_g <= 21'd144179;
            r_gamma_b <= 21'd144179;
            r_formats <= '0;
            r_deep    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EXP_R:   r_exp_r   <= $signed(i_cfg_data[14:0]);
                REG_EXP_G:   r_exp_g   <= $signed(i_cfg_data[14:0]);
                REG_EXP_B:   r_exp_b   <= $signed(i_cfg_data[14:0]);
                REG_GAMMA_R: r_gamma_r <= i_cfg_data;
                REG_GAMMA_G: r_gamma_g <= i_cfg_data;
                REG_GAMMA_B: r_gamma_b <= i_cfg_data;
                REG_FORMATS: r_formats <= i_cfg_data[5:0];
                REG_DEEP:    r_deep    <= i_cfg_data[0];
                default:     r_deep    <= r_deep;
            endcase
        end
    end

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    logic        v_r, v_g, v_b;
    logic [11:0] lv_r, lv_g, lv_b;

    hpegm_lane u_lane_r (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_sample   (i_red_sample),
        .i_fmt      (t_fmt'(r_formats[1:0])),
        .i_deep     (r_deep),
        .i_exposure (r_exp_r),
        .i_gamma    (r_gamma_r),
        .o_valid    (v_r),
        .o_level    (lv_r)
    );

    hpegm_lane u_lane_g (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_sample   (i_green_sample),
        .i_fmt      (t_fmt'(r_formats[3:2])),
        .i_deep     (r_deep),
        .i_exposure (r_exp_g),
        .i_gamma    (r_gamma_g),
        .o_valid    (v_g),
        .o_level    (lv_g)
    );

    hpegm_lane u_lane_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_sample   (i_blue_sample),
        .i_fmt      (t_fmt'(r_formats[5:4])),
        .i_deep     (r_deep),
        .i_exposure (r_exp_b),
        .i_gamma    (r_gamma_b),
        .o_valid    (v_b),
        .o_level    (lv_b)
    );

    // merge the lanes into one pixel result
    logic        r_strobe;
    logic [11:0] r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= v_r && v_g && v_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= lv_r;
        r_green <= lv_g;
        r_blue  <= lv_b;
    end

    assign o_strobe      = r_strobe;
    assign o_red_level   = r_red;
    assign o_green_level = r_green;
    assign o_blue_level  = r_blue;

endmodule

[hw/rtl/hpegm_checker.sv]
// Port-level checker of the HDR exposure/gamma mapper, bound to the top level.
`include "hdr_pixel_exposure_gamma_map_top_defines.svh"

module hpegm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe
);
    import hpegm_pkg::*;

    `HPEGM_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised on a full-rate pipeline")
    `HPEGM_ASSERT_IMPLIES(a_reset_clears, $past(!i_rst_n), !o_strobe, "strobe right after reset")
    `HPEGM_ASSERT_IMPLIES(a_strobe_has_request, o_strobe, $past(start && !busy, PIPE_DEPTH),
        "strobe without a request one pipeline depth earlier")

endmodule

bind hdr_pixel_exposure_gamma_map_top hpegm_checker u_checker (.*);
